@@ sv/sli_pkg.sv @@
// ----------------------------------------------------------------------------
// sli_pkg
// Shared constants and controller/datapath interface types for the sorted
// insertion list.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int LIST_DEPTH_DEF = 64;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOPOS = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the item and clear the working status
        logic set_full;
        logic set_nopos;
        logic ins_start;  // pointer to the last entry
        logic del_start;  // pointer to the entry being deleted
        logic ptr_inc;
        logic ptr_dec;
        logic rd_head;    // read entry zero instead of the pointer
        logic ins_shift;  // move the read entry one place down
        logic ins_above;  // place the value just below the pointer
        logic ins_put;    // place the value at the head
        logic del_take;   // keep the read entry as the removed value
        logic del_move;   // move the read entry one place up
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic out_load;
    } sli_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic cnt_zero;
        logic pos_bad;
        logic cmp_lt;
        logic ptr_zero;
        logic ptr_last;
    } sli_stat_t;

endpackage

@@ sv/sli_ctrl.sv @@
// ----------------------------------------------------------------------------
// sli_ctrl
// Controller for the sorted insertion list: sequences the shift passes of
// insert and delete and the final head read.
// ----------------------------------------------------------------------------
module sli_ctrl
    import sli_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] op,
    input  sli_stat_t  stat,
    output sli_cmd_t   cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_INS_RD    = 10'b00_0000_0010,
        S_INS_CMP   = 10'b00_0000_0100,
        S_INS_PUT   = 10'b00_0000_1000,
        S_DEL_RD0   = 10'b00_0001_0000,
        S_DEL_TAKE  = 10'b00_0010_0000,
        S_DEL_RD    = 10'b00_0100_0000,
        S_DEL_MOVE  = 10'b00_1000_0000,
        S_HEAD_RD   = 10'b01_0000_0000,
        S_HEAD_CAP  = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    priority if (op == OP_INSERT)
                    begin
                        priority if (stat.full)
                        begin
                            cmd.set_full = 1'b1;
                            state_next   = S_HEAD_RD;
                        end
                        else if (stat.cnt_zero)
                        begin
                            state_next = S_INS_PUT;
                        end
                        else
                        begin
                            cmd.ins_start = 1'b1;
                            state_next    = S_INS_RD;
                        end
                    end
                    else if (op == OP_DELETE)
                    begin
                        if (stat.pos_bad)
                        begin
                            cmd.set_nopos = 1'b1;
                            state_next    = S_HEAD_RD;
                        end
                        else
                        begin
                            cmd.del_start = 1'b1;
                            state_next    = S_DEL_RD0;
                        end
                    end
                    else if (op == OP_CLEAR)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_HEAD_RD;
                    end
                    else
                    begin
                        state_next = S_HEAD_RD;
                    end
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                if (stat.cmp_lt)
                begin
                    cmd.ins_shift = 1'b1;
                    if (stat.ptr_zero)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        cmd.ptr_dec = 1'b1;
                        state_next  = S_INS_RD;
                    end
                end
                else
                begin
                    cmd.ins_above = 1'b1;
                    cmd.cnt_inc   = 1'b1;
                    state_next    = S_HEAD_RD;
                end
            end
            S_INS_PUT:
            begin
                cmd.ins_put = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_next  = S_HEAD_RD;
            end
            S_DEL_RD0, S_DEL_RD:
            begin
                state_next = (state_reg == S_DEL_RD0) ? S_DEL_TAKE : S_DEL_MOVE;
            end
            S_DEL_TAKE, S_DEL_MOVE:
            begin
                cmd.del_take = (state_reg == S_DEL_TAKE);
                cmd.del_move = (state_reg == S_DEL_MOVE);
                if (stat.ptr_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_HEAD_RD;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_DEL_RD;
                end
            end
            S_HEAD_RD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = S_HEAD_CAP;
            end
            S_HEAD_CAP:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_HEAD_CAP);
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

@@ sv/sli_dp.sv @@
// ----------------------------------------------------------------------------
// sli_dp
// Datapath for the sorted insertion list: entry memory with one write and one
// registered read port, the scan pointer, the entry count and result registers.
// ----------------------------------------------------------------------------
module sli_dp
    import sli_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  sli_cmd_t           cmd,
    output sli_stat_t          stat,
    input  logic signed [31:0] value,
    input  logic [6:0]         position,
    output logic [1:0]         status,
    output logic [6:0]         count,
    output logic signed [31:0] head_value,
    output logic signed [31:0] removed_value
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int WW = (CW > 7) ? CW : 7;

    logic signed [31:0] mem [LIST_DEPTH];
    logic signed [31:0] rdata_reg;
    logic [AW-1:0]      rd_addr;
    logic               we;
    logic [AW-1:0]      waddr;
    logic signed [31:0] wdata;

    logic [AW-1:0]      ptr_reg;
    logic [CW-1:0]      count_reg;
    logic signed [31:0] val_reg;
    logic [1:0]         status_w_reg;
    logic signed [31:0] removed_w_reg;

    logic [1:0]         status_out_reg;
    logic [CW-1:0]      count_out_reg;
    logic signed [31:0] head_out_reg;
    logic signed [31:0] removed_out_reg;

    logic [6:0]         idx_in;
    logic [CW+6:0]      count_ext;

    assign idx_in = (position == 7'd0) ? 7'd0 : position - 7'd1;

    assign stat.full     = (count_reg == CW'(LIST_DEPTH));
    assign stat.cnt_zero = (count_reg == '0);
    assign stat.pos_bad  = (WW'(idx_in) >= WW'(count_reg));
    assign stat.cmp_lt   = (rdata_reg < val_reg);
    assign stat.ptr_zero = (ptr_reg == '0);
    assign stat.ptr_last = ((CW'(ptr_reg) + CW'(1)) == count_reg);

    assign rd_addr = cmd.rd_head ? '0 : ptr_reg;

    always_comb
    begin
        we    = 1'b1;
        waddr = ptr_reg + AW'(1);
        wdata = rdata_reg;
        priority if (cmd.ins_shift)
        begin
            waddr = ptr_reg + AW'(1);
            wdata = rdata_reg;
        end
        else if (cmd.ins_above)
        begin
            waddr = ptr_reg + AW'(1);
            wdata = val_reg;
        end
        else if (cmd.ins_put)
        begin
            waddr = '0;
            wdata = val_reg;
        end
        else if (cmd.del_move)
        begin
            waddr = ptr_reg - AW'(1);
            wdata = rdata_reg;
        end
        else
        begin
            we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg <= value;
        end
        priority if (cmd.ins_start)
        begin
            ptr_reg <= AW'(count_reg - CW'(1));
        end
        else if (cmd.del_start)
        begin
            ptr_reg <= AW'(idx_in);
        end
        else if (cmd.ptr_dec)
        begin
            ptr_reg <= ptr_reg - AW'(1);
        end
        else if (cmd.ptr_inc)
        begin
            ptr_reg <= ptr_reg + AW'(1);
        end
        else
        begin
            ptr_reg <= ptr_reg;
        end
        priority if (cmd.set_full)
        begin
            status_w_reg <= ST_FULL;
        end
        else if (cmd.set_nopos)
        begin
            status_w_reg <= ST_NOPOS;
        end
        else if (cmd.load)
        begin
            status_w_reg <= ST_OK;
        end
        else
        begin
            status_w_reg <= status_w_reg;
        end
        priority if (cmd.load)
        begin
            removed_w_reg <= '0;
        end
        else if (cmd.del_take)
        begin
            removed_w_reg <= rdata_reg;
        end
        else
        begin
            removed_w_reg <= removed_w_reg;
        end
        if (cmd.out_load)
        begin
            status_out_reg  <= status_w_reg;
            count_out_reg   <= count_reg;
            head_out_reg    <= (count_reg == '0) ? 32'sd0 : rdata_reg;
            removed_out_reg <= removed_w_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            priority if (cmd.cnt_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            else
            begin
                count_reg <= count_reg;
            end
        end
    end

    assign count_ext     = {7'd0, count_out_reg};
    assign status        = status_out_reg;
    assign count         = count_ext[6:0];
    assign head_value    = head_out_reg;
    assign removed_value = removed_out_reg;

endmodule

@@ sv/sorted_list_insert_delete.sv @@
// Insert moves each entry smaller than the value one place down, then writes the value
// into the freed place or at the head; delete moves every entry below the removed one a
// place up. Each moved entry costs a registered memory read and a compare-and-write step.
// Clear, a full insert, a bad position and the spare code go straight to the head read.
// One item at a time: busy stays high until done, a new item can start in the done cycle,
// and the one-cycle done strobe cannot be stalled. Reset empties the list.
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Bounded list of signed values kept in descending order, with insert,
// delete-at-position and clear operations.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete
    import sli_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic signed [31:0] value,
    input  logic [6:0]         position,
    output logic               done,
    output logic [1:0]         status,
    output logic [6:0]         count,
    output logic signed [31:0] head_value,
    output logic signed [31:0] removed_value
);

    sli_cmd_t  cmd;
    sli_stat_t stat;

    sli_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    sli_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .value         (value),
        .position      (position),
        .status        (status),
        .count         (count),
        .head_value    (head_value),
        .removed_value (removed_value)
    );

    // The result strobe comes after the controller has returned to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && count == 7'd0) |-> (head_value == 32'sd0))
        else $error("empty list reported a nonzero head");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (removed_value == 32'sd0))
        else $error("failed operation reported a removed value");

endmodule
